// ===== hdl/dei_pkg.sv =====
package dei_pkg;

	localparam int MAX_STEPS_DEF = 64;

	// Width of the step_count register and of the clamped node limit.
	localparam int SC_W  = 7;
	localparam int LIM_W = 9;

	localparam int IDX_W = 8;
	localparam int PC_W  = 6;
	localparam logic [PC_W-1:0] PRED_MAX = 6'd63;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_DUP     = 2'd2,
		STATUS_CYCLE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [IDX_W-1:0] before_index;
		logic [IDX_W-1:0] after_index;
	} in_beat_t;

	typedef struct packed {
		status_t         status;
		logic [PC_W-1:0] after_pred_count;
	} out_beat_t;

	typedef struct packed {
		logic done;
		logic found;
	} walk_st_t;

endpackage

// ===== hdl/dei_vmem.sv =====
module dei_vmem #(
	parameter int W     = 64,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data
);

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [W-1:0]     rd_q;
	logic             rd_vld_q;

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== hdl/dei_walk.sv =====
module dei_walk #(
	parameter int MAX_STEPS = 64,
	parameter int IW        = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [IW-1:0]        start_node,
	input  logic [IW-1:0]        target,
	input  logic [MAX_STEPS-1:0] row_data,
	output logic [IW-1:0]        rd_addr,
	output dei_pkg::walk_st_t    st
);
	import dei_pkg::*;

	logic                 busy_q;
	logic                 rd_pend_q;
	logic [MAX_STEPS-1:0] visited_q;
	logic [MAX_STEPS-1:0] pending_q;
	logic [MAX_STEPS-1:0] pick_oh;
	logic [MAX_STEPS-1:0] fresh;
	logic [MAX_STEPS-1:0] start_oh;
	logic                 issue;

	// Pending holds nodes that are visited but whose row has not been fetched yet.
	assign pick_oh  = pending_q & (~pending_q + {{(MAX_STEPS-1){1'b0}}, 1'b1});
	assign issue    = busy_q && (pending_q != '0);
	assign fresh    = rd_pend_q ? (row_data & ~visited_q) : '0;
	assign start_oh = {{(MAX_STEPS-1){1'b0}}, 1'b1} << start_node;

	always_comb begin
		rd_addr = '0;
		for (int i = 0; i < MAX_STEPS; i++) begin
			if (pick_oh[i]) begin
				rd_addr = rd_addr | IW'(i);
			end
		end
	end

	always_comb begin
		st.found = busy_q && rd_pend_q && row_data[target];
		st.done  = st.found || (busy_q && !rd_pend_q && (pending_q == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_pend_q <= 1'b0;
			visited_q <= '0;
			pending_q <= '0;
		end else if (start) begin
			busy_q    <= 1'b1;
			rd_pend_q <= 1'b0;
			visited_q <= start_oh;
			pending_q <= start_oh;
		end else if (busy_q) begin
			if (st.done) begin
				busy_q    <= 1'b0;
				rd_pend_q <= 1'b0;
			end else begin
				rd_pend_q <= issue;
				visited_q <= visited_q | fresh;
				pending_q <= (pending_q & ~pick_oh) | fresh;
			end
		end
	end

endmodule

// ===== hdl/dag_edge_insert_cycle_check.sv =====
// With no walk, a request passes the CHECK and RESULT states and the result beat is registered on leaving
// RESULT; a reachability walk adds the WALK state, which fetches at most one adjacency row per visited node.
// Only one request is handled at a time: in_stall stays high until the block is back in IDLE, and
// output back-pressure can hold the result in RESULT.
// Reset clears the graph at once through per-row valid bits; no clearing pass is needed,
// and step_count returns to zero.
module dag_edge_insert_cycle_check #(
	parameter int MAX_STEPS = dei_pkg::MAX_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [dei_pkg::SC_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  dei_pkg::in_beat_t        in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output dei_pkg::out_beat_t       out_data
);
	import dei_pkg::*;

	localparam int IW = $clog2(MAX_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic [SC_W-1:0]      step_count_q;
	logic                 in_order_q;
	logic [IW-1:0]        before_q, after_q;
	logic                 inval_q;
	logic [MAX_STEPS-1:0] rowb_q;
	out_beat_t            res_q, res_d, out_q;
	logic                 out_valid_q;

	logic [LIM_W-1:0]     limit;
	logic                 in_accept;
	logic                 in_bad;
	logic                 out_free;

	logic [IW-1:0]        mat_raddr, pred_raddr, walk_addr;
	logic [MAX_STEPS-1:0] row_rd, row_cur, after_oh;
	logic [PC_W-1:0]      pred_rd, pred_inc;
	logic                 mat_we, pred_we, walk_start, res_load, in_order_clr, do_commit;
	walk_st_t             walk_st;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// A step_count above the node capacity acts as the capacity.
	assign limit  = (LIM_W'(step_count_q) > LIM_W'(MAX_STEPS)) ? LIM_W'(MAX_STEPS)
	                                                           : LIM_W'(step_count_q);
	assign in_bad = (LIM_W'(in_data.before_index) >= limit) ||
	                (LIM_W'(in_data.after_index) >= limit);

	assign mat_raddr  = (state_q == ST_WALK) ? walk_addr : in_data.before_index[IW-1:0];
	assign pred_raddr = (state_q == ST_IDLE) ? in_data.after_index[IW-1:0] : after_q;
	assign row_cur    = (state_q == ST_WALK) ? rowb_q : row_rd;
	assign after_oh   = {{(MAX_STEPS-1){1'b0}}, 1'b1} << after_q;
	assign pred_inc   = (pred_rd == PRED_MAX) ? pred_rd : pred_rd + PC_W'(1);

	dei_vmem #(
		.W     (MAX_STEPS),
		.DEPTH (MAX_STEPS),
		.AW    (IW)
	) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (mat_raddr),
		.rd_data (row_rd),
		.wr_en   (mat_we),
		.wr_addr (before_q),
		.wr_data (row_cur | after_oh)
	);

	dei_vmem #(
		.W     (PC_W),
		.DEPTH (MAX_STEPS),
		.AW    (IW)
	) u_pred (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (pred_raddr),
		.rd_data (pred_rd),
		.wr_en   (pred_we),
		.wr_addr (after_q),
		.wr_data (pred_inc)
	);

	// The walk asks whether the new destination already reaches the source.
	dei_walk #(
		.MAX_STEPS (MAX_STEPS),
		.IW        (IW)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (walk_start),
		.start_node (after_q),
		.target     (before_q),
		.row_data   (row_rd),
		.rd_addr    (walk_addr),
		.st         (walk_st)
	);

	always_comb begin
		state_d    = state_q;
		walk_start = 1'b0;
		res_load   = 1'b0;
		do_commit  = 1'b0;
		res_d      = '{status: STATUS_OK, after_pred_count: pred_rd};
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (inval_q) begin
					res_load = 1'b1;
					res_d    = '{status: STATUS_INVALID, after_pred_count: '0};
				end else if (before_q == after_q) begin
					res_load     = 1'b1;
					res_d.status = STATUS_CYCLE;
				end else if (row_rd[after_q]) begin
					res_load     = 1'b1;
					res_d.status = STATUS_DUP;
				end else if (in_order_q && (before_q < after_q)) begin
					do_commit = 1'b1;
				end else begin
					walk_start = 1'b1;
					state_d    = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_st.done) begin
					if (walk_st.found) begin
						res_load     = 1'b1;
						res_d.status = STATUS_CYCLE;
					end else begin
						do_commit = 1'b1;
					end
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (do_commit) begin
			res_load = 1'b1;
			res_d    = '{status: STATUS_OK, after_pred_count: pred_inc};
		end
		if (res_load) begin
			state_d = ST_RESULT;
		end
	end

	assign mat_we       = do_commit;
	assign pred_we      = do_commit;
	assign in_order_clr = do_commit && (before_q > after_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_count_q <= '0;
			in_order_q   <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				step_count_q <= cfg_wdata;
			end
			if (in_order_clr) begin
				in_order_q <= 1'b0;
			end
			if ((state_q == ST_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			before_q <= in_data.before_index[IW-1:0];
			after_q  <= in_data.after_index[IW-1:0];
			inval_q  <= in_bad;
		end
		if (state_q == ST_CHECK) begin
			rowb_q <= row_rd;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if ((state_q == ST_RESULT) && out_free) begin
			out_q <= res_q;
		end
	end

`ifndef SYNTH
	a_walk_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_st.done |-> (state_q == ST_WALK))
		else $error("walk finished outside of the walk state");

	a_no_self_edge: assert property (@(posedge clk) disable iff (!arst_n)
		mat_we |-> (before_q != after_q))
		else $error("self edge written to the matrix");

	a_no_dup_insert: assert property (@(posedge clk) disable iff (!arst_n)
		mat_we |-> !row_cur[after_q])
		else $error("edge inserted twice");

	a_ok_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && (res_d.status == STATUS_OK)) |-> (res_d.after_pred_count != '0))
		else $error("accepted edge left a zero predecessor count");

	a_walk_only_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |=> (state_q == ST_WALK) && !walk_st.found)
		else $error("walk started from the wrong state");
`endif

endmodule
